FILE: hw/rtl/bdq_pkg.sv
// Shared types and codes for the bounded deque with search.
// Holds the request/response payloads and the controller/datapath command and status bundles.
// No dependencies.
`default_nettype none

package bdq_pkg;

  // Width of the entry count field in the response
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned VAL_W     = 32;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DELETE     = 3'd4,
    ACT_SEARCH     = 3'd5,
    ACT_REVERSE    = 3'd6,
    ACT_CLEAR      = 3'd7
  } act_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Logical position that the slot calculator translates to a store address
  typedef enum logic [2:0] {
    ADDR_HEAD,   // position 0
    ADDR_NEXT,   // position 1
    ADDR_PREV,   // position -1 (one before the front)
    ADDR_LAST,   // position count-1
    ADDR_TAIL,   // position count
    ADDR_SCAN    // position held in the scan counter
  } addr_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP_FRONT,
    S_POP_BACK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    found;
    logic signed [VAL_W-1:0] removed_value;
    logic [CNT_OUT_W-1:0]    entry_count;
  } rsp_t;

  typedef struct packed {
    addr_sel_e addr_sel;
    logic      req_ld;
    logic      res_clr;
    logic      mem_rd;
    logic      mem_wr_val;
    logic      mem_wr_shift;
    logic      front_ld;
    logic      front_clr;
    logic      rev_tgl;
    logic      rev_clr;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cnt_clr;
    logic      pos_clr;
    logic      pos_inc;
    logic      hole_ld;
    logic      rem_ld;
    logic      st_set;
    status_e   st_val;
    logic      found_set;
    logic      out_ld;
  } dp_cmd_t;

  typedef struct packed {
    act_e action;
    logic full;
    logic empty;
    logic match;
    logic scan_end;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bounded_deque_with_search_top.sv
// Top level of the bounded deque with search: joins the controller and the datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
`default_nettype none

// Bounded double-ended queue of up to MAX_ENTRIES signed 32-bit values with push and
// pop at both ends, delete of the first matching value, search, reverse and clear.
// One request is handled at a time and gives exactly one response; the response sits
// in an output register, so a new request is taken while the previous one waits to be
// collected. A search reads and then compares one entry at a time through the entry
// store's single registered read port, and a delete then closes up the entries
// behind the match, reading each one and writing it into the hole in turn. No
// clearing pass is needed after reset.
module bounded_deque_with_search_top #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bdq_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bdq_pkg::rsp_t      out_rsp_o
);

  bdq_pkg::dp_cmd_t  cmd;
  bdq_pkg::dp_stat_t stat;

  // Sequence each request
  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the entries and build the response
  bdq_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (out_rsp_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/bdq_datapath.sv
// Datapath of the bounded deque: entry store, front/count/direction registers,
// slot address calculation, scan compare and the response register.
// Depends on bdq_pkg.
`default_nettype none

module bdq_datapath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bdq_pkg::req_t    req_i,
  input  wire bdq_pkg::dp_cmd_t cmd_i,
  output bdq_pkg::dp_stat_t     stat_o,
  output bdq_pkg::rsp_t         rsp_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [IDX_W:0]   MAX_X = (IDX_W + 1)'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);

  logic signed [bdq_pkg::VAL_W-1:0] mem_q [MAX_ENTRIES];

  bdq_pkg::req_t                    req_q;
  logic [IDX_W-1:0]                 front_q;
  logic [CNT_W-1:0]                 cnt_q;
  logic                             rev_q;
  logic [CNT_W-1:0]                 pos_q;
  logic [IDX_W-1:0]                 hole_q;
  logic [IDX_W-1:0]                 raddr_q;
  logic signed [bdq_pkg::VAL_W-1:0] rdata_q;
  logic signed [bdq_pkg::VAL_W-1:0] rem_q;
  bdq_pkg::status_e                 st_q;
  logic                             found_q;
  bdq_pkg::rsp_t                    rsp_q;

  logic [CNT_W-1:0]                 pos_c;
  logic                             dir_dn;
  logic [IDX_W:0]                   sum_up;
  logic [IDX_W:0]                   sum_dn;
  logic [IDX_W:0]                   raw;
  logic [IDX_W-1:0]                 slot;
  logic [IDX_W-1:0]                 wr_addr;
  logic signed [bdq_pkg::VAL_W-1:0] wr_data;
  logic                             full;
  logic                             empty;

  // Pick the logical position and walking direction
  always_comb begin
    dir_dn = rev_q;
    case (cmd_i.addr_sel)
      bdq_pkg::ADDR_HEAD: pos_c = '0;
      bdq_pkg::ADDR_NEXT: pos_c = CNT_W'(1);
      bdq_pkg::ADDR_PREV: begin
        pos_c  = CNT_W'(1);
        dir_dn = ~rev_q;
      end
      bdq_pkg::ADDR_LAST: pos_c = cnt_q - CNT_W'(1);
      bdq_pkg::ADDR_TAIL: pos_c = cnt_q;
      bdq_pkg::ADDR_SCAN: pos_c = pos_q;
      default:            pos_c = pos_q;
    endcase
  end

  // Map position to a circular store slot; one conditional subtract wraps it
  assign sum_up = {1'b0, front_q} + {1'b0, pos_c[IDX_W-1:0]};
  assign sum_dn = {1'b0, front_q} + MAX_X - {1'b0, pos_c[IDX_W-1:0]};
  assign raw    = dir_dn ? sum_dn : sum_up;
  assign slot   = (raw >= MAX_X) ? IDX_W'(raw - MAX_X) : raw[IDX_W-1:0];

  // Close-up writes move the read entry into the hole, pushes write the request value
  assign wr_addr = cmd_i.mem_wr_shift ? hole_q : slot;
  assign wr_data = cmd_i.mem_wr_shift ? rdata_q : req_q.value;

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr_val || cmd_i.mem_wr_shift) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[slot];
    end
  end

  // Queue control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      cnt_q   <= '0;
      rev_q   <= 1'b0;
    end else begin
      if (cmd_i.front_clr) begin
        front_q <= '0;
      end else if (cmd_i.front_ld) begin
        front_q <= slot;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.rev_clr) begin
        rev_q <= 1'b0;
      end else if (cmd_i.rev_tgl) begin
        rev_q <= ~rev_q;
      end
    end
  end

  // Request, scan and result payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_ld) begin
      req_q <= req_i;
    end
    if (cmd_i.pos_clr) begin
      pos_q <= '0;
    end else if (cmd_i.pos_inc) begin
      pos_q <= pos_q + CNT_W'(1);
    end
    if (cmd_i.mem_rd) begin
      raddr_q <= slot;
    end
    if (cmd_i.hole_ld) begin
      hole_q <= raddr_q;
    end
    if (cmd_i.res_clr) begin
      st_q    <= bdq_pkg::ST_OK;
      found_q <= 1'b0;
      rem_q   <= '0;
    end else begin
      if (cmd_i.st_set) begin
        st_q <= cmd_i.st_val;
      end
      if (cmd_i.found_set) begin
        found_q <= 1'b1;
      end
      if (cmd_i.rem_ld) begin
        rem_q <= rdata_q;
      end
    end
    if (cmd_i.out_ld) begin
      rsp_q.status        <= st_q;
      rsp_q.found         <= found_q;
      rsp_q.removed_value <= rem_q;
      rsp_q.entry_count   <= bdq_pkg::CNT_OUT_W'(cnt_q);
    end
  end

  assign full  = (cnt_q == MAX_C);
  assign empty = (cnt_q == '0);

  assign stat_o.action   = bdq_pkg::act_e'(req_q.action);
  assign stat_o.full     = full;
  assign stat_o.empty    = empty;
  assign stat_o.match    = (rdata_q == req_q.value);
  assign stat_o.scan_end = (pos_q == cnt_q);

  assign rsp_o = rsp_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_C)
    else $error("entry count above capacity");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> !full)
    else $error("insert into a full store");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> !empty)
    else $error("remove from an empty store");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, front_q} < MAX_X)
    else $error("front index outside the store");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/bdq_ctrl.sv
// Controller of the bounded deque: sequences each request through the datapath
// and runs the request/response handshakes.
// Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire bdq_pkg::dp_stat_t stat_i,
  output bdq_pkg::dp_cmd_t       cmd_o
);

  bdq_pkg::state_e  state_q;
  bdq_pkg::state_e  state_d;
  logic             out_valid_q;
  bdq_pkg::dp_cmd_t cmd;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = bdq_pkg::S_EXEC;
        end
      end
      bdq_pkg::S_EXEC: begin
        case (stat_i.action)
          bdq_pkg::ACT_POP_FRONT:
            state_d = stat_i.empty ? bdq_pkg::S_DONE : bdq_pkg::S_POP_FRONT;
          bdq_pkg::ACT_POP_BACK:
            state_d = stat_i.empty ? bdq_pkg::S_DONE : bdq_pkg::S_POP_BACK;
          bdq_pkg::ACT_DELETE, bdq_pkg::ACT_SEARCH:
            state_d = stat_i.empty ? bdq_pkg::S_DONE : bdq_pkg::S_SCAN_RD;
          default:
            state_d = bdq_pkg::S_DONE;
        endcase
      end
      bdq_pkg::S_POP_FRONT: state_d = bdq_pkg::S_DONE;
      bdq_pkg::S_POP_BACK:  state_d = bdq_pkg::S_DONE;
      bdq_pkg::S_SCAN_RD:   state_d = bdq_pkg::S_SCAN_CMP;
      bdq_pkg::S_SCAN_CMP: begin
        if (stat_i.match) begin
          state_d = (stat_i.action == bdq_pkg::ACT_DELETE) ? bdq_pkg::S_SHIFT_RD
                                                           : bdq_pkg::S_DONE;
        end else if (stat_i.scan_end) begin
          state_d = bdq_pkg::S_DONE;
        end else begin
          state_d = bdq_pkg::S_SCAN_RD;
        end
      end
      bdq_pkg::S_SHIFT_RD: begin
        state_d = stat_i.scan_end ? bdq_pkg::S_DONE : bdq_pkg::S_SHIFT_WR;
      end
      bdq_pkg::S_SHIFT_WR: state_d = bdq_pkg::S_SHIFT_RD;
      bdq_pkg::S_DONE: begin
        if (out_free) begin
          state_d = bdq_pkg::S_IDLE;
        end
      end
      default: state_d = bdq_pkg::S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd          = '0;
    cmd.addr_sel = bdq_pkg::ADDR_SCAN;
    cmd.st_val   = bdq_pkg::ST_OK;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd.req_ld  = 1'b1;
          cmd.res_clr = 1'b1;
          cmd.pos_clr = 1'b1;
        end
      end
      bdq_pkg::S_EXEC: begin
        case (stat_i.action)
          bdq_pkg::ACT_PUSH_FRONT: begin
            if (stat_i.full) begin
              cmd.st_set = 1'b1;
              cmd.st_val = bdq_pkg::ST_FULL;
            end else begin
              cmd.addr_sel   = bdq_pkg::ADDR_PREV;
              cmd.mem_wr_val = 1'b1;
              cmd.front_ld   = 1'b1;
              cmd.cnt_inc    = 1'b1;
            end
          end
          bdq_pkg::ACT_PUSH_BACK: begin
            if (stat_i.full) begin
              cmd.st_set = 1'b1;
              cmd.st_val = bdq_pkg::ST_FULL;
            end else begin
              cmd.addr_sel   = bdq_pkg::ADDR_TAIL;
              cmd.mem_wr_val = 1'b1;
              cmd.cnt_inc    = 1'b1;
            end
          end
          bdq_pkg::ACT_POP_FRONT: begin
            cmd.addr_sel = bdq_pkg::ADDR_HEAD;
            cmd.mem_rd   = !stat_i.empty;
            cmd.st_set   = stat_i.empty;
            cmd.st_val   = bdq_pkg::ST_EMPTY;
          end
          bdq_pkg::ACT_POP_BACK: begin
            cmd.addr_sel = bdq_pkg::ADDR_LAST;
            cmd.mem_rd   = !stat_i.empty;
            cmd.st_set   = stat_i.empty;
            cmd.st_val   = bdq_pkg::ST_EMPTY;
          end
          bdq_pkg::ACT_DELETE, bdq_pkg::ACT_SEARCH: begin
            cmd.st_set = stat_i.empty;
            cmd.st_val = bdq_pkg::ST_EMPTY;
          end
          bdq_pkg::ACT_REVERSE: begin
            // New front is the old last entry
            cmd.addr_sel = bdq_pkg::ADDR_LAST;
            cmd.front_ld = !stat_i.empty;
            cmd.rev_tgl  = 1'b1;
          end
          bdq_pkg::ACT_CLEAR: begin
            cmd.cnt_clr   = 1'b1;
            cmd.front_clr = 1'b1;
            cmd.rev_clr   = 1'b1;
          end
          default: ;
        endcase
      end
      bdq_pkg::S_POP_FRONT: begin
        cmd.rem_ld   = 1'b1;
        cmd.addr_sel = bdq_pkg::ADDR_NEXT;
        cmd.front_ld = 1'b1;
        cmd.cnt_dec  = 1'b1;
      end
      bdq_pkg::S_POP_BACK: begin
        cmd.rem_ld  = 1'b1;
        cmd.cnt_dec = 1'b1;
      end
      bdq_pkg::S_SCAN_RD: begin
        cmd.addr_sel = bdq_pkg::ADDR_SCAN;
        cmd.mem_rd   = 1'b1;
        cmd.pos_inc  = 1'b1;
      end
      bdq_pkg::S_SCAN_CMP: begin
        if (stat_i.match) begin
          cmd.found_set = 1'b1;
          if (stat_i.action == bdq_pkg::ACT_DELETE) begin
            cmd.rem_ld  = 1'b1;
            cmd.hole_ld = 1'b1;
          end
        end else if (stat_i.scan_end) begin
          cmd.st_set = 1'b1;
          cmd.st_val = bdq_pkg::ST_NOT_FOUND;
        end
      end
      bdq_pkg::S_SHIFT_RD: begin
        if (stat_i.scan_end) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.addr_sel = bdq_pkg::ADDR_SCAN;
          cmd.mem_rd   = 1'b1;
          cmd.pos_inc  = 1'b1;
        end
      end
      bdq_pkg::S_SHIFT_WR: begin
        // Move the entry just read into the hole; its old slot becomes the hole
        cmd.mem_wr_shift = 1'b1;
        cmd.hole_ld      = 1'b1;
      end
      bdq_pkg::S_DONE: begin
        cmd.out_ld = out_free;
      end
      default: ;
    endcase
  end

  // State and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == bdq_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> (!out_valid_q || out_ready_i))
    else $error("pending response overwritten");

  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdq_pkg::S_SCAN_CMP |-> $past(state_q) == bdq_pkg::S_SCAN_RD)
    else $error("compare without a preceding read");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdq_pkg::S_SHIFT_WR |-> $past(state_q) == bdq_pkg::S_SHIFT_RD)
    else $error("close-up write without a preceding read");
`endif

endmodule

`default_nettype wire
